// ----- sv/jpdm_pkg.sv -----
// Shared types, constants and helpers for the joystick packet drive mixer.
// No dependencies; imported by every module of the block.
package jpdm_pkg;

    localparam int DEF_NUM_AXES    = 8;
    localparam int DEF_NUM_BUTTONS = 16;

    localparam logic [7:0] HDR_AXES   = 8'h80;
    localparam logic [7:0] HDR_BUTTON = 8'h81;
    localparam logic [7:0] BTN_ON     = 8'd1;
    localparam int         POWER_MAX  = 99;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_LIFT_MIN   = 3'd0;
    localparam logic [2:0] REG_LIFT_MAX   = 3'd1;
    localparam logic [2:0] REG_GRIP_MIN   = 3'd2;
    localparam logic [2:0] REG_GRIP_MAX   = 3'd3;
    localparam logic [2:0] REG_LIFT_START = 3'd4;
    localparam logic [2:0] REG_GRIP_START = 3'd5;

    localparam logic [7:0] RST_SERVO_MIN   = 8'd0;
    localparam logic [7:0] RST_SERVO_MAX   = 8'd180;
    localparam logic [7:0] RST_SERVO_START = 8'd90;

    typedef enum logic [1:0] {
        EV_DRIVE   = 2'd0,
        EV_SERVO   = 2'd1,
        EV_AXC_ERR = 2'd2,
        EV_BTN_ERR = 2'd3
    } t_event;

    typedef logic signed [1:0] t_rate;

    // up wins over down
    function automatic t_rate rate_sel(input logic up, input logic down);
        t_rate r;
        r = 2'sd0;
        if (up) begin
            r = 2'sd1;
        end else if (down) begin
            r = -2'sd1;
        end
        return r;
    endfunction

    function automatic logic signed [7:0] clamp_power(input logic signed [9:0] v);
        logic signed [9:0] lim;
        logic signed [7:0] r;
        lim = $signed(10'(POWER_MAX));
        if (v < -lim) begin
            r = -8'(POWER_MAX);
        end else if (v > lim) begin
            r = 8'(POWER_MAX);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/joystick_packet_drive_mixer.sv -----
// Joystick packet parser, drive mixer and two rate-driven servo positions.
// Depends on jpdm_pkg, jpdm_mix, jpdm_servo.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------------
//  s_axis    | in  | tuser[0] kind (0 byte, 1 tick); tdata[7:0] rx_byte
//  m_axis    | out | tuser[1:0] event; tdata left, right, lift, grip positions
//  apb       | in  | six 8-bit registers at 4*i: limits and start positions
//
// One beat per cycle when not stalled; a result appears in the output register
// the cycle after its input beat. s_axis_tready drops only while the output
// register holds a beat the sink has not taken. Synchronous reset returns the
// parser to idle, clears axes and buttons, restores the registers and sets both
// positions to 90. Stray bytes and packet bytes before the last give no result.
module joystick_packet_drive_mixer #(
    parameter int NUM_AXES    = jpdm_pkg::DEF_NUM_AXES,
    parameter int NUM_BUTTONS = jpdm_pkg::DEF_NUM_BUTTONS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] rx_byte
    input  logic [0:0]                        i_s_axis_tuser,  // [0] kind
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] left_power, [15:8] right_power, [23:16] lift_position,
    // [31:24] grip_position
    output logic [31:0]                       o_m_axis_tdata,
    output logic [1:0]                        o_m_axis_tuser,  // [1:0] event_res
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jpdm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import jpdm_pkg::*;

    localparam int AW = $clog2(NUM_AXES);
    localparam int BW = $clog2(NUM_BUTTONS);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_AXCNT  = 5'b00010,
        PH_AXDATA = 5'b00100,
        PH_BTNIDX = 5'b01000,
        PH_BTNVAL = 5'b10000
    } t_phase;

    // configuration
    logic [7:0] r_lift_min, r_lift_max, r_grip_min, r_grip_max;
    logic [7:0] r_lift_start, r_grip_start;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // parser and servo state; only entries that feed the mixer or the servos are kept
    t_phase            r_phase,      n_phase;
    logic [AW-1:0]     r_axes_exp,   n_axes_exp;
    logic [AW-1:0]     r_axis_ptr,   n_axis_ptr;
    logic [BW-1:0]     r_btn_ptr,    n_btn_ptr;
    logic signed [7:0] r_a2,         n_a2;
    logic signed [7:0] r_a3,         n_a3;
    logic [3:0]        r_btn_on,     n_btn_on;   // buttons 4..7 equal to one
    logic [7:0]        r_lift_pos,   n_lift_pos;
    logic [7:0]        r_grip_pos,   n_grip_pos;

    // output register
    logic              r_m_valid;
    t_event            r_m_event;
    logic signed [7:0] r_m_left, r_m_right;
    logic [7:0]        r_m_lift, r_m_grip;

    logic              accept;
    logic              emit;
    t_event            ev;
    logic [7:0]        rx;
    logic signed [7:0] mix_left, mix_right;
    logic [7:0]        lift_step, grip_step;
    t_rate             lift_rate, grip_rate;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lift_min   <= RST_SERVO_MIN;
            r_lift_max   <= RST_SERVO_MAX;
            r_grip_min   <= RST_SERVO_MIN;
            r_grip_max   <= RST_SERVO_MAX;
            r_lift_start <= RST_SERVO_START;
            r_grip_start <= RST_SERVO_START;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LIFT_MIN:   r_lift_min   <= pwdata[7:0];
                REG_LIFT_MAX:   r_lift_max   <= pwdata[7:0];
                REG_GRIP_MIN:   r_grip_min   <= pwdata[7:0];
                REG_GRIP_MAX:   r_grip_max   <= pwdata[7:0];
                REG_LIFT_START: r_lift_start <= pwdata[7:0];
                REG_GRIP_START: r_grip_start <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LIFT_MIN:   prdata = {24'd0, r_lift_min};
            REG_LIFT_MAX:   prdata = {24'd0, r_lift_max};
            REG_GRIP_MIN:   prdata = {24'd0, r_grip_min};
            REG_GRIP_MAX:   prdata = {24'd0, r_grip_max};
            REG_LIFT_START: prdata = {24'd0, r_lift_start};
            REG_GRIP_START: prdata = {24'd0, r_grip_start};
            default:        prdata = 32'd0;
        endcase
    end

    // rates only change on a completed packet, so they follow the button bits
    assign lift_rate = rate_sel(r_btn_on[2], r_btn_on[0]);
    assign grip_rate = rate_sel(r_btn_on[1], r_btn_on[3]);

    jpdm_servo u_lift (
        .i_pos  (r_lift_pos),
        .i_rate (lift_rate),
        .i_min  (r_lift_min),
        .i_max  (r_lift_max),
        .o_pos  (lift_step)
    );

    jpdm_servo u_grip (
        .i_pos  (r_grip_pos),
        .i_rate (grip_rate),
        .i_min  (r_grip_min),
        .i_max  (r_grip_max),
        .o_pos  (grip_step)
    );

    jpdm_mix u_mix (
        .i_a2    (n_a2),
        .i_a3    (n_a3),
        .o_left  (mix_left),
        .o_right (mix_right)
    );

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign rx              = i_s_axis_tdata;

    always_comb begin
        n_phase    = r_phase;
        n_axes_exp = r_axes_exp;
        n_axis_ptr = r_axis_ptr;
        n_btn_ptr  = r_btn_ptr;
        n_a2       = r_a2;
        n_a3       = r_a3;
        n_btn_on   = r_btn_on;
        n_lift_pos = r_lift_pos;
        n_grip_pos = r_grip_pos;
        emit       = 1'b0;
        ev         = EV_DRIVE;
        if (accept) begin
            if (i_s_axis_tuser[0] == KIND_TICK) begin
                n_lift_pos = lift_step;
                n_grip_pos = grip_step;
                emit       = 1'b1;
                ev         = EV_SERVO;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (rx == HDR_AXES) begin
                            n_phase = PH_AXCNT;
                        end else if (rx == HDR_BUTTON) begin
                            n_phase = PH_BTNIDX;
                        end
                    end
                    PH_AXCNT: begin
                        if ({1'b0, rx} >= 9'(NUM_AXES)) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            ev      = EV_AXC_ERR;
                        end else begin
                            n_axes_exp = rx[AW-1:0];
                            n_axis_ptr = '0;
                            if (rx == 8'd0) begin
                                n_phase = PH_IDLE;
                                emit    = 1'b1;
                            end else begin
                                n_phase = PH_AXDATA;
                            end
                        end
                    end
                    PH_AXDATA: begin
                        if (r_axis_ptr == AW'(2)) begin
                            n_a2 = $signed(rx);
                        end
                        if (r_axis_ptr == AW'(3)) begin
                            n_a3 = $signed(rx);
                        end
                        n_axis_ptr = r_axis_ptr + AW'(1);
                        if (n_axis_ptr >= r_axes_exp) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                        end
                    end
                    PH_BTNIDX: begin
                        if ({1'b0, rx} >= 9'(NUM_BUTTONS)) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            ev      = EV_BTN_ERR;
                        end else begin
                            n_btn_ptr = rx[BW-1:0];
                            n_phase   = PH_BTNVAL;
                        end
                    end
                    PH_BTNVAL: begin
                        for (int i = 0; i < 4; i++) begin
                            if (r_btn_ptr == BW'(i + 4)) begin
                                n_btn_on[i] = (rx == BTN_ON);
                            end
                        end
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_axes_exp <= '0;
            r_axis_ptr <= '0;
            r_btn_ptr  <= '0;
            r_a2       <= '0;
            r_a3       <= '0;
            r_btn_on   <= '0;
            r_lift_pos <= RST_SERVO_START;
            r_grip_pos <= RST_SERVO_START;
        end else begin
            r_phase    <= n_phase;
            r_axes_exp <= n_axes_exp;
            r_axis_ptr <= n_axis_ptr;
            r_btn_ptr  <= n_btn_ptr;
            r_a2       <= n_a2;
            r_a3       <= n_a3;
            r_btn_on   <= n_btn_on;
            r_lift_pos <= n_lift_pos;
            r_grip_pos <= n_grip_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_m_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && emit) begin
            r_m_event <= ev;
            r_m_left  <= (ev == EV_DRIVE) ? mix_left  : 8'sd0;
            r_m_right <= (ev == EV_DRIVE) ? mix_right : 8'sd0;
            r_m_lift  <= n_lift_pos;
            r_m_grip  <= n_grip_pos;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_event;
    assign o_m_axis_tdata  = {r_m_grip, r_m_lift, r_m_right, r_m_left};

endmodule

// ----- sv/jpdm_mix.sv -----
// Differential drive mixer: axes 2 and 3 to clamped left/right power.
// Depends on jpdm_pkg.
module jpdm_mix (
    input  logic signed [7:0] i_a2,
    input  logic signed [7:0] i_a3,
    output logic signed [7:0] o_left,
    output logic signed [7:0] o_right
);
    import jpdm_pkg::*;

    logic signed [8:0] a2_adj;
    logic signed [9:0] half;
    logic signed [9:0] neg_a3;
    logic signed [9:0] left_raw;
    logic signed [9:0] right_raw;

    // a2/2 truncated toward zero
    assign a2_adj = {i_a2[7], i_a2} + {8'd0, i_a2[7]};
    assign half   = {{2{a2_adj[8]}}, a2_adj[8:1]};
    assign neg_a3 = -{{2{i_a3[7]}}, i_a3};

    always_comb begin
        if (i_a3 <= 8'sd0) begin
            left_raw  = neg_a3 + half;
            right_raw = neg_a3 - half;
        end else begin
            left_raw  = neg_a3 - half;
            right_raw = neg_a3 + half;
        end
    end

    assign o_left  = clamp_power(left_raw);
    assign o_right = clamp_power(right_raw);

endmodule

// ----- sv/jpdm_servo.sv -----
// One servo position step: add rate, clamp to min (tested first) then max.
// Depends on jpdm_pkg.
module jpdm_servo (
    input  logic [7:0]           i_pos,
    input  jpdm_pkg::t_rate      i_rate,
    input  logic [7:0]           i_min,
    input  logic [7:0]           i_max,
    output logic [7:0]           o_pos
);
    import jpdm_pkg::*;

    logic signed [9:0] sum;
    logic signed [9:0] lo;
    logic signed [9:0] hi;

    assign sum = $signed({2'b00, i_pos}) + $signed({{8{i_rate[1]}}, i_rate});
    assign lo  = $signed({2'b00, i_min});
    assign hi  = $signed({2'b00, i_max});

    always_comb begin
        if (sum < lo) begin
            o_pos = i_min;
        end else if (sum > hi) begin
            o_pos = i_max;
        end else begin
            o_pos = sum[7:0];
        end
    end

endmodule

// ----- sv/jpdm_checker.sv -----
// Port-level checks for the joystick packet drive mixer, bound to the top level.
// Depends on jpdm_pkg and joystick_packet_drive_mixer.
module jpdm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [0:0]                      i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [31:0]                     o_m_axis_tdata,
    input logic [1:0]                      o_m_axis_tuser
);
    import jpdm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == KIND_TICK |=>
            o_m_axis_tvalid && o_m_axis_tuser == EV_SERVO)
        else $error("tick did not give a servo beat");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            $signed(o_m_axis_tdata[7:0]) >= -8'sd99 &&
            $signed(o_m_axis_tdata[7:0]) <= 8'sd99 &&
            $signed(o_m_axis_tdata[15:8]) >= -8'sd99 &&
            $signed(o_m_axis_tdata[15:8]) <= 8'sd99)
        else $error("drive power out of range");

    a_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != EV_DRIVE |-> o_m_axis_tdata[15:0] == 16'd0)
        else $error("non-drive beat carries power");

endmodule

bind joystick_packet_drive_mixer jpdm_checker u_jpdm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
